>>> rtl/core/hrpc_pkg.sv
// hrpc_pkg: shared types, constants and bin mapping functions for the
// histogram rarity pixel classifier; used by hrpc_ctrl, hrpc_dp and the top level
`default_nettype none

package hrpc_pkg;

	// histogram geometry
	localparam int HUE_BINS   = 32;
	localparam int VAL_BINS   = 32;
	localparam int HUE_LIMIT  = 180;
	localparam int VAL_LIMIT  = 256;
	localparam int COUNT_BITS = 20;

	// field widths
	localparam int CHAN_W    = 8;
	localparam int OP_W      = 2;
	localparam int THR_W     = 20;
	localparam int REG_IDX_W = 1;
	localparam int IN_DATA_W  = 2 * CHAN_W;
	localparam int OUT_DATA_W = 8;

	localparam int HUE_IDX_W = $clog2(HUE_BINS);
	localparam int VAL_IDX_W = $clog2(VAL_BINS);
	localparam int SWEEP_LEN = (HUE_BINS > VAL_BINS) ? HUE_BINS : VAL_BINS;
	localparam int SWEEP_W   = $clog2(SWEEP_LEN);
	localparam int CMP_W     = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	// reciprocals of LIMIT / BINS, rounded up; the error stays far below one
	// bin step for every 8-bit channel, so the mapping is exact
	localparam int BIN_SHIFT = 16;
	localparam int HUE_RECIP = ((HUE_BINS << BIN_SHIFT) + HUE_LIMIT - 1) / HUE_LIMIT;
	localparam int VAL_RECIP = ((VAL_BINS << BIN_SHIFT) + VAL_LIMIT - 1) / VAL_LIMIT;

	// product widths for channel * reciprocal
	localparam int HUE_PROD_W = CHAN_W + $clog2(HUE_RECIP + 1);
	localparam int VAL_PROD_W = CHAN_W + $clog2(VAL_RECIP + 1);

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_HUE_THR = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_VAL_THR = REG_IDX_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 2'd0,
		OP_ACCUM    = 2'd1,
		OP_CLASSIFY = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ACCUM,
		ST_CLASS
	} state_t;

	typedef struct packed {
		logic capture;   // register incoming pixel, restart sweep counter
		logic clr_step;  // zero one bin of each histogram
		logic accum;     // bump the captured bins
		logic classify;  // load the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;  // sweep is at its final bin
		logic out_free;  // result register can take a new result
	} dp_sts_t;

	function automatic logic hue_in_range(input logic [CHAN_W-1:0] ch);
		return (CHAN_W + 1)'(ch) < (CHAN_W + 1)'(HUE_LIMIT);
	endfunction

	function automatic logic val_in_range(input logic [CHAN_W-1:0] ch);
		return (CHAN_W + 1)'(ch) < (CHAN_W + 1)'(VAL_LIMIT);
	endfunction

	// floor(ch * HUE_BINS / HUE_LIMIT) as a reciprocal multiply and shift
	function automatic logic [HUE_IDX_W-1:0] hue_bin(input logic [CHAN_W-1:0] ch);
		logic [HUE_PROD_W-1:0] prod;
		prod = HUE_PROD_W'(ch) * HUE_PROD_W'(HUE_RECIP);
		return HUE_IDX_W'(prod >> BIN_SHIFT);
	endfunction

	function automatic logic [VAL_IDX_W-1:0] val_bin(input logic [CHAN_W-1:0] ch);
		logic [VAL_PROD_W-1:0] prod;
		prod = VAL_PROD_W'(ch) * VAL_PROD_W'(VAL_RECIP);
		return VAL_IDX_W'(prod >> BIN_SHIFT);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/hrpc_ctrl.sv
// hrpc_ctrl: sequencer for the classifier; takes input transfers and
// issues commands to hrpc_dp. depends on hrpc_pkg
`default_nettype none

module hrpc_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [hrpc_pkg::OP_W-1:0] s_tuser,
	output hrpc_pkg::ctrl_cmd_t            cmd,
	input  wire hrpc_pkg::dp_sts_t         sts
);
	import hrpc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					case (opcode_t'(s_tuser))
						OP_CLEAR:    state_d = ST_CLEAR;
						OP_ACCUM:    state_d = ST_ACCUM;
						OP_CLASSIFY: state_d = ST_CLASS;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_CLASS: begin
				// hold until the result register drains
				if (sts.out_free) begin
					cmd.classify = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/hrpc_dp.sv
// hrpc_dp: datapath with bin mapping, both histograms, thresholds and the
// result register. depends on hrpc_pkg, driven by hrpc_ctrl
`default_nettype none

module hrpc_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hrpc_pkg::ctrl_cmd_t             cmd,
	output hrpc_pkg::dp_sts_t                    sts,
	input  wire logic [hrpc_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [hrpc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [hrpc_pkg::THR_W-1:0]      cfg_data,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [hrpc_pkg::OUT_DATA_W-1:0]      m_tdata
);
	import hrpc_pkg::*;

	logic [CHAN_W-1:0] hue_in;
	logic [CHAN_W-1:0] val_in;

	logic [HUE_IDX_W-1:0] hue_bin_q;
	logic                 hue_ok_q;
	logic [VAL_IDX_W-1:0] val_bin_q;
	logic                 val_ok_q;
	logic [SWEEP_W-1:0]   clr_idx_q;

	logic [THR_W-1:0] hue_thr_q;
	logic [THR_W-1:0] val_thr_q;

	logic [COUNT_BITS-1:0] hue_cnt_q [HUE_BINS];
	logic [COUNT_BITS-1:0] val_cnt_q [VAL_BINS];

	logic [COUNT_BITS-1:0] hue_cur;
	logic [COUNT_BITS-1:0] val_cur;
	logic                  hue_rare;
	logic                  val_rare;
	logic                  clr_hue_hit;
	logic                  clr_val_hit;

	logic       out_valid_q;
	logic [2:0] out_flags_q;

	assign hue_in = s_tdata[CHAN_W-1:0];
	assign val_in = s_tdata[2*CHAN_W-1:CHAN_W];

	// captured pixel and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.capture) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + SWEEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hue_bin_q <= hue_bin(hue_in);
			hue_ok_q  <= hue_in_range(hue_in);
			val_bin_q <= val_bin(val_in);
			val_ok_q  <= val_in_range(val_in);
		end
	end

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_thr_q <= '0;
			val_thr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUE_THR: hue_thr_q <= cfg_data;
				REG_VAL_THR: val_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign clr_hue_hit = (SWEEP_W + 1)'(clr_idx_q) < (SWEEP_W + 1)'(HUE_BINS);
	assign clr_val_hit = (SWEEP_W + 1)'(clr_idx_q) < (SWEEP_W + 1)'(VAL_BINS);

	assign hue_cur = hue_cnt_q[hue_bin_q];
	assign val_cur = val_cnt_q[val_bin_q];

	// histogram stores, saturating counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HUE_BINS; i++) begin
				hue_cnt_q[i] <= '0;
			end
			for (int i = 0; i < VAL_BINS; i++) begin
				val_cnt_q[i] <= '0;
			end
		end else if (cmd.clr_step) begin
			if (clr_hue_hit) begin
				hue_cnt_q[clr_idx_q[HUE_IDX_W-1:0]] <= '0;
			end
			if (clr_val_hit) begin
				val_cnt_q[clr_idx_q[VAL_IDX_W-1:0]] <= '0;
			end
		end else if (cmd.accum) begin
			if (hue_ok_q && (hue_cur != '1)) begin
				hue_cnt_q[hue_bin_q] <= hue_cur + COUNT_BITS'(1);
			end
			if (val_ok_q && (val_cur != '1)) begin
				val_cnt_q[val_bin_q] <= val_cur + COUNT_BITS'(1);
			end
		end
	end

	// out of range channel reads as count zero
	assign hue_rare = CMP_W'(hue_ok_q ? hue_cur : '0) < CMP_W'(hue_thr_q);
	assign val_rare = CMP_W'(val_ok_q ? val_cur : '0) < CMP_W'(val_thr_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.classify) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			out_flags_q <= {val_rare, hue_rare, hue_rare | val_rare};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - 3)'(0), out_flags_q};

	assign sts.clr_last = (clr_idx_q == SWEEP_W'(SWEEP_LEN - 1));
	assign sts.out_free = !out_valid_q || m_tready;

endmodule

`default_nettype wire

>>> rtl/core/histogram_rarity_pixel_classifier.sv
// histogram rarity pixel classifier: one item in flight, result register on the output
// accumulate and classify: capture in idle, then one histogram read/update per item
// classify result is registered from the ST_CLASS state that follows its input transfer;
// that state holds while the previous result still waits for m_tready
// clear: sweeps max(HUE_BINS, VAL_BINS) bins, one bin of each store a cycle
// unused opcode: ignored. reset clears thresholds, all bin counts and the output valid
// depends on hrpc_pkg, hrpc_ctrl, hrpc_dp
`default_nettype none

module histogram_rarity_pixel_classifier (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input pixel stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [hrpc_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] hue, [15:8] value
	input  wire logic [hrpc_pkg::OP_W-1:0]       s_tuser,   // [1:0] opcode
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [hrpc_pkg::OUT_DATA_W-1:0]      m_tdata,   // [0] obstacle, [1] hue_rare,
	                                                        // [2] value_rare, [7:3] zero
	// threshold write port
	input  wire logic                            cfg_we,
	input  wire logic [hrpc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [hrpc_pkg::THR_W-1:0]      cfg_data
);
	import hrpc_pkg::*;

	// command and status between sequencer and datapath
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: accepts a transfer only when idle, then walks the op
	hrpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: bin mapping at capture, histogram update or compare, result register
	hrpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	// a result only appears after a classify command
	a_result_from_classify: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.classify))
		else $error("result valid without classify");

	// no input transfer while the clear sweep runs
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !s_tready)
		else $error("input ready during clear sweep");

	// an accepted clear starts the sweep on the next cycle
	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_CLEAR)) |=> cmd.clr_step)
		else $error("clear transfer did not start the sweep");

	// classify never overwrites a result that is still waiting
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.classify && m_tvalid) |-> m_tready)
		else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking bench for histogram_rarity_pixel_classifier
// streams clear/accumulate/classify/unused-opcode pixels, predicts each rarity flag and compares it
// depends on hrpc_pkg and the histogram_rarity_pixel_classifier top level

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hrpc_pkg::*;

	// opcode the block ignores
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	// clear walks every bin once, so allow a full sweep plus slack before going idle
	localparam int DRAIN_CYCLES = SWEEP_LEN + 8;
	// cycles with no transfer or register write before the run is declared hung
	localparam int HANG_LIMIT = 1000;

	// result word as it sits in m_tdata[2:0]
	typedef struct packed {
		logic value_rare;
		logic hue_rare;
		logic obstacle;
	} verdict_t;

	// shadow histograms and thresholds; turns accepted pixels into due verdicts
	class rarity_tracker;
		logic [COUNT_BITS-1:0] hue_hist [HUE_BINS];
		logic [COUNT_BITS-1:0] val_hist [VAL_BINS];
		logic [THR_W-1:0]      hue_thr;
		logic [THR_W-1:0]      val_thr;
		verdict_t              due [$];
		int                    fails;

		function new();
			hue_thr = '0;
			val_thr = '0;
			fails   = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (hue_hist[i]) hue_hist[i] = '0;
			foreach (val_hist[i]) val_hist[i] = '0;
		endfunction

		function void set_threshold(logic [REG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
			if (idx == REG_HUE_THR) hue_thr = data;
			else if (idx == REG_VAL_THR) val_thr = data;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_pixel(logic [OP_W-1:0] op, logic [CHAN_W-1:0] hue,
				logic [CHAN_W-1:0] val);
			int                    hb;
			int                    vb;
			bit                    hue_ok;
			bit                    val_ok;
			logic [COUNT_BITS-1:0] hc;
			logic [COUNT_BITS-1:0] vc;
			verdict_t              v;
			hue_ok = int'(hue) < HUE_LIMIT;
			val_ok = int'(val) < VAL_LIMIT;
			hb = int'(hue) * HUE_BINS / HUE_LIMIT;
			vb = int'(val) * VAL_BINS / VAL_LIMIT;
			case (op)
				OP_CLEAR: wipe();
				OP_ACCUM: begin
					// counters stick at all ones
					if (hue_ok && hue_hist[hb] != '1) hue_hist[hb] = hue_hist[hb] + 1'b1;
					if (val_ok && val_hist[vb] != '1) val_hist[vb] = val_hist[vb] + 1'b1;
				end
				OP_CLASSIFY: begin
					// a channel with no bin reads as an empty bin
					hc = '0;
					vc = '0;
					if (hue_ok) hc = hue_hist[hb];
					if (val_ok) vc = val_hist[vb];
					v.hue_rare   = hc < hue_thr;
					v.value_rare = vc < val_thr;
					v.obstacle   = v.hue_rare | v.value_rare;
					due.push_back(v);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			fails++;
			$display("ERROR %0t: %s", $time, msg);
		endtask

		task check_verdict(logic [OUT_DATA_W-1:0] word);
			verdict_t want;
			if (due.size() == 0) begin
				report($sformatf("result %b with no classify outstanding", word));
				return;
			end
			want = due.pop_front();
			if (word[0] !== want.obstacle)
				report($sformatf("obstacle %b, want %b", word[0], want.obstacle));
			if (word[1] !== want.hue_rare)
				report($sformatf("hue_rare %b, want %b", word[1], want.hue_rare));
			if (word[2] !== want.value_rare)
				report($sformatf("value_rare %b, want %b", word[2], want.value_rare));
			if (word[OUT_DATA_W-1:3] !== '0)
				report($sformatf("pad bits %b not zero", word[OUT_DATA_W-1:3]));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // [7:0] hue, [15:8] value
	logic [OP_W-1:0]       s_tuser   = '0;  // [1:0] opcode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [0] obstacle, [1] hue_rare, [2] value_rare
	logic                  cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [THR_W-1:0]      cfg_data  = '0;

	// chance in percent that a transfer is preceded by an idle burst, per side
	int src_gap_pct  = 30;
	int sink_gap_pct = 30;

	rarity_tracker tracker = new();

	histogram_rarity_pixel_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random back-pressure bursts, steady ready when the gap chance is zero
	initial begin : result_sink
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < sink_gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// every result transfer is checked against the oldest due verdict
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_verdict(m_tdata);
	end

	// hang detector: any transfer or register write restarts the count
	initial begin : hang_watch
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// one pixel transfer, optionally after an idle burst; leaves tvalid high
	task automatic send_pixel(logic [OP_W-1:0] op, logic [CHAN_W-1:0] hue,
			logic [CHAN_W-1:0] val);
		if ($urandom_range(0, 99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, hue};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_pixel(op, hue, val);
	endtask

	// stop sending, collect every due verdict, then give a clear time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_threshold(idx, data);
		@(posedge clk);
	endtask

	// narrow picks crowd a few bins so counts climb high
	function automatic logic [CHAN_W-1:0] pick_hue(bit narrow);
		if (narrow) return CHAN_W'($urandom_range(0, 11));
		if ($urandom_range(0, 9) == 0) return CHAN_W'($urandom_range(HUE_LIMIT, 255));
		return CHAN_W'($urandom_range(0, HUE_LIMIT - 1));
	endfunction

	function automatic logic [CHAN_W-1:0] pick_value(bit narrow);
		if (narrow) return CHAN_W'($urandom_range(0, 15));
		return CHAN_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return OP_CLEAR;
		if (r < 5) return OP_SPARE;
		if (r < 50) return OP_ACCUM;
		return OP_CLASSIFY;
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold(bit narrow);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		if (narrow) return THR_W'($urandom_range(4, 30));
		return THR_W'($urandom_range(1, 4));
	endfunction

	initial begin : stimulus
		int  phase;
		bit  narrow;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// thresholds come out of reset at zero: nothing is rare
		send_pixel(OP_CLASSIFY, 8'd0, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd255, 8'd255);
		settle();

		write_reg(REG_HUE_THR, THR_W'(1));
		write_reg(REG_VAL_THR, THR_W'(1));
		// empty histograms, including a hue with no bin
		send_pixel(OP_CLASSIFY, 8'd0, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd179, 8'd255);
		send_pixel(OP_CLASSIFY, 8'd180, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd255, 8'd128);
		// edge channels; hue 180 and 255 must not be counted
		send_pixel(OP_ACCUM, 8'd0, 8'd0);
		send_pixel(OP_ACCUM, 8'd179, 8'd255);
		send_pixel(OP_ACCUM, 8'd180, 8'd128);
		send_pixel(OP_ACCUM, 8'd255, 8'd7);
		send_pixel(OP_ACCUM, 8'd5, 8'd0);
		// ignored opcode, with every data bit both ways
		send_pixel(OP_SPARE, 8'd0, 8'd0);
		send_pixel(OP_SPARE, 8'd255, 8'd255);
		send_pixel(OP_CLASSIFY, 8'd0, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd179, 8'd255);
		send_pixel(OP_CLASSIFY, 8'd180, 8'd128);
		// bin boundary: hue 6 and value 8 open bin 1, still empty, so both flags set
		send_pixel(OP_CLASSIFY, 8'd6, 8'd8);
		send_pixel(OP_CLEAR, 8'd0, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd0, 8'd0);
		settle();

		// threshold extremes, one channel at a time
		write_reg(REG_HUE_THR, '1);
		write_reg(REG_VAL_THR, '0);
		send_pixel(OP_ACCUM, 8'd0, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd0, 8'd0);
		send_pixel(OP_CLASSIFY, 8'd255, 8'd255);
		settle();
		write_reg(REG_HUE_THR, '0);
		write_reg(REG_VAL_THR, '1);
		send_pixel(OP_CLASSIFY, 8'd179, 8'd200);
		send_pixel(OP_CLASSIFY, 8'd0, 8'd0);
		settle();

		// deep fill of a few bins, then thresholds placed right at the counts
		src_gap_pct  = 20;
		sink_gap_pct = 20;
		send_pixel(OP_CLEAR, 8'd0, 8'd0);
		repeat (200) send_pixel(OP_ACCUM, pick_hue(1'b1), pick_value(1'b1));
		settle();
		write_reg(REG_HUE_THR, tracker.hue_hist[0]);
		write_reg(REG_VAL_THR, tracker.val_hist[1] + 1'b1);
		repeat (30) send_pixel(OP_CLASSIFY, pick_hue(1'b1), pick_value(1'b1));
		settle();

		// mixed traffic under several threshold settings and idle patterns;
		// the last phase runs with no idling on either side
		for (phase = 0; phase < 4; phase++) begin
			narrow = phase[0];
			write_reg(REG_HUE_THR, pick_threshold(narrow));
			write_reg(REG_VAL_THR, pick_threshold(narrow));
			if (phase == 3) begin
				src_gap_pct  = 0;
				sink_gap_pct = 0;
			end else begin
				src_gap_pct  = $urandom_range(0, 2) * 25;
				sink_gap_pct = $urandom_range(0, 2) * 25;
			end
			repeat (70) send_pixel(pick_op(), pick_hue(narrow), pick_value(narrow));
			settle();
		end

		if (tracker.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
